[rtl/indexed_array_insert_delete_search_macros.svh]
// Assertion macros shared by the RTL of the indexed array block.
`ifndef INDEXED_ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH
`define INDEXED_ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IADS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iads: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IADS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iads: next-cycle check failed");

`endif

[rtl/iads_pkg.sv]
package iads_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 32;
  localparam int REQ_W     = 2;
  localparam int ST_W      = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd3;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;   // open a slot at the position and load the new value
    logic del;   // close the slot at the position
    logic clr;   // clear the search carry
    logic run;   // advance the search carry by one cell
  } cell_ctl_t;

endpackage

[rtl/indexed_array_insert_delete_search.sv]
// Ordered array of up to DEPTH signed 32-bit values with insert, delete and
// search. Requests arrive on a valid/ready channel (req_type, position,
// item_value) and each one produces exactly one result transaction on a
// valid/ready channel (status, found, entry_count).
// Inserts, deletes and the unused request code complete in the cycle of
// acceptance: the chain of cells shifts in that cycle and the result is
// registered, so it is offered in the next cycle. A new request is taken in
// every cycle while no search runs and the result register is empty or is
// being drained. A search clears a hit carry in every cell and then lets it
// ripple along the chain, one cell per cycle; once the carry has passed the
// last cell the result is registered and offered, and no request is taken
// meanwhile. The ripple through the chain of cells sets the search time.
// Reset clears the state, the count, the search carries and the result valid
// flag; the stored values stay undefined until written, which is never
// observable. When the receiver stalls, the result is held and no new request
// is taken until the result register is free again.
module indexed_array_insert_delete_search
  import iads_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int SW   = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REQ_W-1:0]        req_type,
  input  logic [CW-1:0]           position,
  input  logic signed [VAL_W-1:0] item_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ST_W-1:0]         status,
  output logic                    found,
  output logic [CW-1:0]           entry_count
);

  `include "indexed_array_insert_delete_search_macros.svh"

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] LAST_STEP = SW'(DEPTH);

  logic                    state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [SW-1:0]           step;
  logic signed [VAL_W-1:0] srch_value;

  logic                    accept;
  logic                    load_out;
  logic [ST_W-1:0]         st_next;
  logic                    found_next;
  logic [CW-1:0]           pos_eff;
  cell_ctl_t               ctl;

  logic signed [VAL_W-1:0] entry_w [DEPTH];
  logic                    carry_w [DEPTH];

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // An insert past the end is clamped to the count, so it appends.
  assign pos_eff = (position > count) ? count : position;

  always_comb begin
    state_next = state;
    count_next = count;
    st_next    = ST_OK;
    found_next = 1'b0;
    load_out   = 1'b0;
    ctl        = '0;
    if (state == S_IDLE) begin
      if (accept) begin
        unique case (req_type)
          REQ_INSERT: begin
            load_out = 1'b1;
            if (count == FULL_CNT) begin
              st_next = ST_FULL;
            end else begin
              ctl.ins    = 1'b1;
              count_next = count + 1'b1;
            end
          end
          REQ_DELETE: begin
            load_out = 1'b1;
            if (count == '0) begin
              st_next = ST_EMPTY;
            end else if (position >= count) begin
              st_next = ST_BAD_INDEX;
            end else begin
              ctl.del    = 1'b1;
              count_next = count - 1'b1;
            end
          end
          REQ_SEARCH: begin
            ctl.clr    = 1'b1;
            state_next = S_SEARCH;
          end
          default: begin
            load_out = 1'b1;
          end
        endcase
      end
    end else begin
      // After DEPTH ripple steps the last carry covers the whole chain.
      if (step == LAST_STEP) begin
        load_out   = 1'b1;
        found_next = carry_w[DEPTH-1];
        state_next = S_IDLE;
      end else begin
        ctl.run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      srch_value <= item_value;
      step       <= '0;
    end else if (ctl.run) begin
      step <= step + 1'b1;
    end
    if (load_out) begin
      status      <= st_next;
      found       <= found_next;
      entry_count <= count_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] prev_e;
    logic signed [VAL_W-1:0] next_e;
    logic                    c_in;

    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign c_in   = 1'b0;
    end else begin : g_body
      assign prev_e = entry_w[i-1];
      assign c_in   = carry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_e = entry_w[i];
    end else begin : g_mid
      assign next_e = entry_w[i+1];
    end

    iads_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .pos        (pos_eff),
      .count      (count),
      .wr_value   (item_value),
      .srch_value (srch_value),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .carry_in   (c_in),
      .entry      (entry_w[i]),
      .carry      (carry_w[i])
    );
  end

  // The count never grows beyond the capacity of the chain.
  `IADS_ASSERT_SAME(a_count_bound, 1'b1, count <= FULL_CNT)
  // A search leaves the count untouched while the carry ripples.
  `IADS_ASSERT_NEXT(a_search_keeps_count, state == S_SEARCH, count == $past(count))
  // An insert into a full array changes nothing and reports full.
  `IADS_ASSERT_NEXT(a_full_insert,
    accept && (req_type == REQ_INSERT) && (count == FULL_CNT),
    (count == FULL_CNT) && out_valid && (status == ST_FULL))

endmodule

[rtl/iads_cell.sv]
module iads_cell
  import iads_pkg::*;
#(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cell_ctl_t               ctl,
  input  logic [CW-1:0]           pos,
  input  logic [CW-1:0]           count,
  input  logic signed [VAL_W-1:0] wr_value,
  input  logic signed [VAL_W-1:0] srch_value,
  input  logic signed [VAL_W-1:0] prev_entry,
  input  logic signed [VAL_W-1:0] next_entry,
  input  logic                    carry_in,
  output logic signed [VAL_W-1:0] entry,
  output logic                    carry
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic live;
  logic match;

  assign live  = MY_IDX < count;
  assign match = live && (entry == srch_value);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (MY_IDX > pos) begin
        entry <= prev_entry;
      end else if (MY_IDX == pos) begin
        entry <= wr_value;
      end
    end else if (ctl.del && (MY_IDX >= pos)) begin
      entry <= next_entry;
    end
  end

  // The search carry ripples one cell per cycle towards the end of the chain.
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      carry <= 1'b0;
    end else if (ctl.run) begin
      carry <= carry_in | match;
    end
  end

endmodule

[test/indexed_array_insert_delete_search_test.sv]
`timescale 1ns / 1ps

// Testbench for the ordered array with insert, delete and linear search.
//
// A shadow copy of the array is kept as a queue of signed values. Every
// request transaction that the block accepts is applied to the shadow at
// the moment of acceptance. The reply that the shadow predicts (status,
// found flag and new count) is appended to a queue of pending replies. A
// separate process pops the oldest pending reply for every result
// transaction and compares it field by field.
//
// The stimulus runs in the following order:
// - a short directed section that covers the empty array, the value
//   extremes, clamped and out-of-range indexes and the unused request code;
// - a sweep that fills the array to capacity and drains it again;
// - long stretches of random traffic that drift between full and empty;
// - a back-pressure section, in which the receiver holds off for a long time so that
//   the result register stays occupied and the input stalls, and more random traffic.
//
// Idling on both channels is random. The sender idles first with a chance of 38
// percent and the receiver with a chance of 59. The two figures are then swapped,
// and at the end neither side idles.
module indexed_array_insert_delete_search_test;
  import iads_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int CW = $clog2(DEPTH + 1);
  // Request code that the block treats as a no-operation.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  // Length of the long receiver hold-off, in clock cycles.
  localparam int HOLD_CYCLES = 300;
  // Settling time after the last reply.
  localparam int SETTLE_CYCLES = DEPTH + 8;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic found;
    logic [CW-1:0] entry_count;
  } reply_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [REQ_W-1:0] req_type;
  logic [CW-1:0] position;
  logic signed [VAL_W-1:0] item_value;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ST_W-1:0] status;
  logic found;
  logic [CW-1:0] entry_count;

  // Shadow copy of the valid entries, in array order.
  logic signed [VAL_W-1:0] shadow_entries[$];
  // Replies that are predicted but not yet returned, oldest first.
  reply_t pending_replies[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The test sequence increments hold_requests to ask for a long hold-off.
  // The receiver process notices the change and counts the cycles itself.
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  // These figures feed the summary at the end of the run.
  int n_requests = 0;
  int n_replies = 0;
  int n_inserts = 0;
  int n_deletes = 0;
  int n_searches = 0;
  int n_unused = 0;
  int n_hits = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_bad_index = 0;
  int peak_count = 0;

  indexed_array_insert_delete_search dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .position    (position),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found       (found),
    .entry_count (entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one accepted request to the shadow array and returns the reply
  // that the block must give for it.
  function automatic reply_t apply_request(logic [REQ_W-1:0] kind, logic [CW-1:0] pos,
                                           logic signed [VAL_W-1:0] val);
    reply_t r;
    int idx;
    r = '0;
    case (kind)
      REQ_INSERT: begin
        n_inserts++;
        if (shadow_entries.size() >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          // An index past the count appends the value.
          idx = (int'(pos) > shadow_entries.size()) ? shadow_entries.size() : int'(pos);
          shadow_entries.insert(idx, val);
        end
      end
      REQ_DELETE: begin
        n_deletes++;
        if (shadow_entries.size() == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else if (int'(pos) >= shadow_entries.size()) begin
          r.status = ST_BAD_INDEX;
          n_bad_index++;
        end else begin
          shadow_entries.delete(int'(pos));
        end
      end
      REQ_SEARCH: begin
        n_searches++;
        foreach (shadow_entries[i]) begin
          if (shadow_entries[i] == val) r.found = 1'b1;
        end
        if (r.found) n_hits++;
      end
      default: n_unused++;
    endcase
    r.entry_count = CW'(shadow_entries.size());
    if (shadow_entries.size() > peak_count) peak_count = shadow_entries.size();
    return r;
  endfunction

  // Draws values that favour the extremes and a small pool around zero. The
  // small pool makes duplicates, so a search can match more than one entry.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return {1'b1, {(VAL_W-1){1'b0}}};
      1: return {1'b0, {(VAL_W-1){1'b1}}};
      2, 3: return VAL_W'($urandom_range(6)) - VAL_W'(3);
      default: return $urandom;
    endcase
  endfunction

  // Half of all searches look for a value that is present, if there is one.
  function automatic logic signed [VAL_W-1:0] pick_search_value();
    if (shadow_entries.size() != 0 && $urandom_range(1) == 1)
      return shadow_entries[$urandom_range(shadow_entries.size() - 1)];
    return pick_value();
  endfunction

  // Most indexes land inside the array. The rest hit the capacity DEPTH,
  // the count itself, index zero or any value from zero to DEPTH.
  function automatic logic [CW-1:0] pick_position(logic [REQ_W-1:0] kind);
    int sz;
    sz = shadow_entries.size();
    case ($urandom_range(9))
      0: return CW'(DEPTH);
      1: return CW'($urandom_range(DEPTH));
      2: return '0;
      3: return CW'(sz);
      default: begin
        if (kind == REQ_INSERT) return CW'($urandom_range(sz));
        return CW'((sz == 0) ? 0 : $urandom_range(sz - 1));
      end
    endcase
  endfunction

  // Offers one request transaction and returns at the edge where it is
  // accepted. Before the offer the sender may idle. It lowers valid only
  // while it idles, so that valid stays high between back-to-back requests.
  task automatic send_req(logic [REQ_W-1:0] kind, logic [CW-1:0] pos,
                          logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    position <= pos;
    item_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_requests++;
    pending_replies.push_back(apply_request(kind, pos, val));
  endtask

  // Stops offering requests and waits until every pending reply is back.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Requests against an empty array. None of them may change the count.
  task automatic test_empty_array();
    send_req(REQ_DELETE, '0, '0);
    send_req(REQ_DELETE, CW'(DEPTH), '0);
    send_req(REQ_SEARCH, '0, '0);
    send_req(REQ_UNUSED, CW'(DEPTH), '1);
    pause_until_drained();
  endtask

  // Value extremes, clamped inserts, out-of-range deletes, deletes at the
  // first, last and middle entries, and the unused code on a non-empty array.
  task automatic test_edges();
    send_req(REQ_INSERT, CW'(DEPTH), {1'b0, {(VAL_W-1){1'b1}}});
    send_req(REQ_INSERT, '0, {1'b1, {(VAL_W-1){1'b0}}});
    send_req(REQ_INSERT, CW'(DEPTH), '0);
    send_req(REQ_INSERT, CW'(1), '1);
    send_req(REQ_INSERT, CW'(4), VAL_W'(5));
    send_req(REQ_SEARCH, '0, {1'b0, {(VAL_W-1){1'b1}}});
    send_req(REQ_SEARCH, '0, {1'b1, {(VAL_W-1){1'b0}}});
    send_req(REQ_SEARCH, CW'(DEPTH), '0);
    send_req(REQ_SEARCH, '0, VAL_W'(1));
    send_req(REQ_SEARCH, '0, '1);
    send_req(REQ_DELETE, CW'(DEPTH), '0);
    send_req(REQ_DELETE, CW'(5), '0);
    send_req(REQ_UNUSED, CW'(2), VAL_W'(5));
    send_req(REQ_DELETE, '0, '0);
    send_req(REQ_DELETE, CW'(3), '0);
    send_req(REQ_DELETE, CW'(1), '0);
    send_req(REQ_SEARCH, '0, {1'b1, {(VAL_W-1){1'b0}}});
    send_req(REQ_SEARCH, '0, '1);
    send_req(REQ_DELETE, '0, '0);
    send_req(REQ_DELETE, '0, '0);
    send_req(REQ_DELETE, '0, '0);
    pause_until_drained();
  endtask

  // Fills the array to capacity, pushes against the full array, and then
  // empties it again, with searches mixed in. Positions and values are random.
  task automatic test_capacity_sweep();
    while (shadow_entries.size() < DEPTH)
      send_req(REQ_INSERT, pick_position(REQ_INSERT), pick_value());
    repeat (3) send_req(REQ_INSERT, pick_position(REQ_INSERT), pick_value());
    repeat (4) send_req(REQ_SEARCH, '0, pick_search_value());
    while (shadow_entries.size() != 0) begin
      if ($urandom_range(9) == 0) send_req(REQ_SEARCH, '0, pick_search_value());
      else send_req(REQ_DELETE, pick_position(REQ_DELETE), '0);
    end
    send_req(REQ_DELETE, pick_position(REQ_DELETE), '0);
    pause_until_drained();
  endtask

  // Random traffic that drifts towards full and then back towards empty, so
  // that the count keeps sweeping its whole range.
  task automatic test_random_mix(int n_items);
    bit growing;
    int roll;
    logic [REQ_W-1:0] kind;
    growing = 1'b1;
    repeat (n_items) begin
      if (shadow_entries.size() == DEPTH && $urandom_range(3) == 0) growing = 1'b0;
      if (shadow_entries.size() == 0 && $urandom_range(3) == 0) growing = 1'b1;
      roll = $urandom_range(99);
      if (roll < 2) kind = REQ_UNUSED;
      else if (roll < 20) kind = REQ_SEARCH;
      else if (roll < (growing ? 75 : 45)) kind = REQ_INSERT;
      else kind = REQ_DELETE;
      case (kind)
        REQ_SEARCH: send_req(kind, pick_position(kind), pick_search_value());
        REQ_UNUSED: send_req(kind, CW'($urandom_range(DEPTH)), $urandom);
        default: send_req(kind, pick_position(kind), pick_value());
      endcase
    end
    pause_until_drained();
  endtask

  // The receiver holds off for HOLD_CYCLES while the sender keeps offering
  // requests. The result register stays occupied, so the input has to stall.
  task automatic test_output_backpressure();
    hold_requests++;
    repeat (40) begin
      if ($urandom_range(4) == 0) send_req(REQ_SEARCH, '0, pick_search_value());
      else if ($urandom_range(1) == 0) send_req(REQ_INSERT, pick_position(REQ_INSERT),
                                                pick_value());
      else send_req(REQ_DELETE, pick_position(REQ_DELETE), '0);
    end
    pause_until_drained();
  endtask

  // Receiver: random idling, and a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result transaction is compared with the oldest pending reply.
  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      n_replies++;
      if (pending_replies.size() == 0) begin
        $error("result with nothing pending: status %0d found %0d entry_count %0d",
               status, found, entry_count);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          errors++;
        end
        if (found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, found);
          errors++;
        end
        if (entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_INSERT;
    position = '0;
    item_value = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 59;
    test_empty_array();
    test_edges();
    test_capacity_sweep();
    test_random_mix(350);

    send_idle_pct = 59;
    recv_idle_pct = 38;
    test_random_mix(400);
    test_output_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(420);

    // Give any stray result time to show up after the last expected reply.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $error("%0d replies never arrived", pending_replies.size());
      errors++;
    end

    $write("Run covered %0d requests and %0d replies: %0d inserts, %0d deletes, ",
           n_requests, n_replies, n_inserts, n_deletes);
    $display("%0d searches (%0d hits), %0d unused codes.", n_searches, n_hits, n_unused);
    $display("Status codes seen: full %0d, empty %0d, bad index %0d; peak count %0d of %0d.",
             n_full, n_empty, n_bad_index, peak_count, DEPTH);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog. The slowest correct run stays far below this time.
  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

endmodule
